/* rtl/dufr_pkg.sv */
package dufr_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int STORE_AW      = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    localparam logic [7:0]  HDR_FIRST  = 8'h5A;
    localparam logic [7:0]  HDR_SECOND = 8'hA5;
    localparam logic [7:0]  CMD_WR     = 8'h82;
    localparam logic [7:0]  CMD_RD     = 8'h83;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_MATCH   = 3'd0,
        KIND_TOUCH   = 3'd1,
        KIND_CRC_ERR = 3'd2,
        KIND_DROP    = 3'd3,
        KIND_READ    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_HDR1    = 2'd0,
        PH_HDR2    = 2'd1,
        PH_LEN     = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  frame_command;
        logic [15:0] vp_address;
        logic [15:0] key_value;
        logic [7:0]  frame_length;
        logic        read_hit;
    } stage_t;

    // CRC-16/Modbus, one byte, reflected
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/dufr_item_if.sv */
interface dufr_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [7:0]  pending_command;
    logic [15:0] pending_address;
    logic [7:0]  read_index;

    modport source (
        output valid, func, rx_byte, pending_command, pending_address, read_index,
        input  ready
    );
    modport sink (
        input  valid, func, rx_byte, pending_command, pending_address, read_index,
        output ready
    );
endinterface

/* rtl/dufr_result_if.sv */
interface dufr_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  frame_command;
    logic [15:0] vp_address;
    logic [15:0] key_value;
    logic [7:0]  frame_length;
    logic [7:0]  read_data;

    modport source (
        output valid, kind, frame_command, vp_address, key_value, frame_length, read_data,
        input  ready
    );
    modport sink (
        input  valid, kind, frame_command, vp_address, key_value, frame_length, read_data,
        output ready
    );
endinterface

/* rtl/dufr_store.sv */
module dufr_store
    import dufr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  store_wr_t           wr,
    input  logic                rd_en,
    input  logic [STORE_AW-1:0] rd_addr,
    output logic [7:0]          rd_data,
    output logic                rd_valid
);

    logic [7:0]               mem_array [PAYLOAD_DEPTH];
    logic [7:0]               rd_data_reg;
    logic                     rd_valid_reg;
    logic [PAYLOAD_DEPTH-1:0] valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_array[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    // unwritten entries return rd_valid low
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

/* rtl/dufr_parser.sv */
module dufr_parser
    import dufr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                accept,
    input  func_t               func,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          pending_command,
    input  logic [15:0]         pending_address,
    input  logic [7:0]          read_index,
    output logic                stage_valid,
    output stage_t              stage,
    output store_wr_t           store_wr,
    output logic                rd_en,
    output logic [STORE_AW-1:0] rd_addr
);

    phase_t      phase_reg, phase_next;
    logic        crc_enable_reg;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] rcrc_reg, rcrc_next;
    logic        pend_valid_reg;
    logic [7:0]  pend_cmd_reg;
    logic [15:0] pend_addr_reg;
    logic [7:0]  b0_reg, b1_reg, b2_reg, b4_reg, b5_reg;
    logic [7:0]  b0_next, b1_next, b2_next, b4_next, b5_next;

    logic        is_byte;
    logic [8:0]  count_inc;
    logic        payload_done;
    logic        finish;
    logic [7:0]  f_cmd;
    logic [15:0] f_addr;
    logic [15:0] f_key;
    logic        crc_bad;
    kind_t       f_kind;

    assign is_byte      = accept && (func == FUNC_BYTE);
    assign count_inc    = {1'b0, byte_count_reg} + 9'd1;
    assign payload_done = count_inc >= {1'b0, frame_len_reg};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (is_byte)
        begin
            case (phase_reg)
                PH_HDR1:    phase_next = (rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HDR1;
                PH_HDR2:    phase_next = (rx_byte == HDR_SECOND) ? PH_LEN : PH_HDR1;
                PH_LEN:     phase_next = (rx_byte == 8'h00) ? PH_HDR1 : PH_PAYLOAD;
                PH_PAYLOAD: phase_next = payload_done ? PH_HDR1 : PH_PAYLOAD;
                default:    phase_next = PH_HDR1;
            endcase
        end
    end

    // datapath updates per phase
    always_comb
    begin
        frame_len_next  = frame_len_reg;
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        rcrc_next       = rcrc_reg;
        b0_next         = b0_reg;
        b1_next         = b1_reg;
        b2_next         = b2_reg;
        b4_next         = b4_reg;
        b5_next         = b5_reg;
        store_wr        = '0;
        finish          = 1'b0;
        if (is_byte)
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    frame_len_next  = rx_byte;
                    byte_count_next = 8'h00;
                    crc_next        = CRC_INIT;
                    rcrc_next       = 16'h0000;
                    finish          = (rx_byte == 8'h00);
                end
                PH_PAYLOAD:
                begin
                    store_wr.we   = {1'b0, byte_count_reg} < 9'(PAYLOAD_DEPTH);
                    store_wr.addr = byte_count_reg[STORE_AW-1:0];
                    store_wr.data = rx_byte;
                    // trailing two bytes carry the CRC
                    if (({1'b0, byte_count_reg} + 9'd2) < {1'b0, frame_len_reg})
                    begin
                        crc_next = crc16_byte(crc_reg, rx_byte);
                    end
                    rcrc_next       = {rx_byte, rcrc_reg[15:8]};
                    byte_count_next = count_inc[7:0];
                    if (byte_count_reg == 8'd0) b0_next = rx_byte;
                    if (byte_count_reg == 8'd1) b1_next = rx_byte;
                    if (byte_count_reg == 8'd2) b2_next = rx_byte;
                    if (byte_count_reg == 8'd4) b4_next = rx_byte;
                    if (byte_count_reg == 8'd5) b5_next = rx_byte;
                    finish = payload_done;
                end
                default:
                begin
                    finish = 1'b0;
                end
            endcase
        end
    end

    // frame fields; bytes past the length read as zero
    always_comb
    begin
        f_cmd  = (frame_len_next > 8'd0) ? b0_next : 8'h00;
        f_addr = {(frame_len_next > 8'd1) ? b1_next : 8'h00,
                  (frame_len_next > 8'd2) ? b2_next : 8'h00};
        f_key  = {(frame_len_next > 8'd4) ? b4_next : 8'h00,
                  (frame_len_next > 8'd5) ? b5_next : 8'h00};
        crc_bad = crc_enable_reg && ((frame_len_next < 8'd2) || (crc_next != rcrc_next));
        if (crc_bad)
        begin
            f_kind = KIND_CRC_ERR;
        end
        else if (pend_valid_reg && (f_cmd == pend_cmd_reg))
        begin
            if ((f_cmd == CMD_WR) || ((f_cmd == CMD_RD) && (f_addr == pend_addr_reg)))
            begin
                f_kind = KIND_MATCH;
            end
            else
            begin
                f_kind = KIND_DROP;
            end
        end
        else
        begin
            f_kind = KIND_TOUCH;
        end
    end

    assign rd_en   = accept && (func == FUNC_READ);
    assign rd_addr = read_index[STORE_AW-1:0];

    always_comb
    begin
        stage       = '0;
        stage_valid = finish || rd_en;
        if (rd_en)
        begin
            stage.kind     = KIND_READ;
            stage.read_hit = (read_index < frame_len_reg)
                          && ({1'b0, read_index} < 9'(PAYLOAD_DEPTH));
        end
        else
        begin
            stage.kind          = f_kind;
            stage.frame_command = f_cmd;
            stage.vp_address    = f_addr;
            stage.key_value     = f_key;
            stage.frame_length  = frame_len_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR1;
            crc_enable_reg <= 1'b0;
            byte_count_reg <= 8'h00;
            frame_len_reg  <= 8'h00;
            crc_reg        <= CRC_INIT;
            rcrc_reg       <= 16'h0000;
            pend_valid_reg <= 1'b0;
            pend_cmd_reg   <= 8'h00;
            pend_addr_reg  <= 16'h0000;
        end
        else
        begin
            phase_reg      <= phase_next;
            byte_count_reg <= byte_count_next;
            frame_len_reg  <= frame_len_next;
            crc_reg        <= crc_next;
            rcrc_reg       <= rcrc_next;
            if (cfg_we)
            begin
                crc_enable_reg <= cfg_wdata;
            end
            if (accept && (func == FUNC_SET))
            begin
                pend_valid_reg <= 1'b1;
                pend_cmd_reg   <= pending_command;
                pend_addr_reg  <= pending_address;
            end
            else if (accept && (func == FUNC_CLEAR))
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b0_reg <= b0_next;
        b1_reg <= b1_next;
        b2_reg <= b2_next;
        b4_reg <= b4_next;
        b5_reg <= b5_next;
    end

endmodule

/* rtl/display_uart_frame_receiver_core.sv */
// Frame receiver for a serial display link.
// item channel: one beat per received byte (func byte), or a command beat that
// sets or clears the pending request, or reads one stored payload byte.
// result channel: one beat at the end of each frame (matched, dropped, touch or
// CRC error) and one beat per read command; other beats give no result.
// crc_enable_we/crc_enable_wdata write the CRC check enable; write it only
// while no beat is in flight.
// Throughput: one item beat per cycle while item.ready is high. A result passes
// through the stage register, loaded together with the registered read port of
// the payload memory, and then through the output register.
// Reset: the parser hunts for the first header byte, the pending request is
// cleared, CRC checking is off and every payload byte reads as zero.
// When the result side stalls, the stage register and the output register fill
// and item.ready drops; it rises again as soon as the output register drains.
module display_uart_frame_receiver_core
    import dufr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 crc_enable_we,
    input  logic                 crc_enable_wdata,
    dufr_item_if.sink            item,
    dufr_result_if.source        result
);

    logic                s1_valid_reg;
    stage_t              s1_reg;
    logic                out_valid_reg;
    stage_t              out_reg;
    logic [7:0]          out_data_reg;

    logic                out_free;
    logic                accept;
    func_t               func;
    logic                stage_valid;
    stage_t              stage;
    store_wr_t           store_wr;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic [7:0]          rd_data;
    logic                rd_valid;

    assign func       = func_t'(item.func);
    assign out_free   = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || out_free;
    assign accept     = item.valid && item.ready;

    dufr_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (crc_enable_we),
        .cfg_wdata       (crc_enable_wdata),
        .accept          (accept),
        .func            (func),
        .rx_byte         (item.rx_byte),
        .pending_command (item.pending_command),
        .pending_address (item.pending_address),
        .read_index      (item.read_index),
        .stage_valid     (stage_valid),
        .stage           (stage),
        .store_wr        (store_wr),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr)
    );

    dufr_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (store_wr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= accept && stage_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= stage;
        end
        // advance stage into output register, merging the memory read
        if (s1_valid_reg && out_free)
        begin
            out_reg      <= s1_reg;
            out_data_reg <= (s1_reg.read_hit && rd_valid) ? rd_data : 8'h00;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.kind          = out_reg.kind;
    assign result.frame_command = out_reg.frame_command;
    assign result.vp_address    = out_reg.vp_address;
    assign result.key_value     = out_reg.key_value;
    assign result.frame_length  = out_reg.frame_length;
    assign result.read_data     = out_data_reg;

`ifndef NO_ASSERTIONS
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("stage register changed while stalled");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_READ)) |=> (s1_valid_reg && (s1_reg.kind == KIND_READ)))
        else $error("read beat did not produce a read result");

    a_pend_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((func == FUNC_SET) || (func == FUNC_CLEAR))) |=> !s1_valid_reg)
        else $error("pending request beat produced a result");

    a_frame_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind != KIND_READ)) |-> (out_data_reg == 8'h00))
        else $error("frame result carries read data");
`endif

endmodule
